// ===== rtl/ndps_pkg.sv =====
// Shared types, constants and the sigmoid lookup table for the neuron block.
package ndps_pkg;

  // Fixed widths of the arithmetic.
  localparam int unsigned AccWidth  = 40;
  localparam int unsigned FracBits  = 12;
  localparam int unsigned OutWidth  = 16;
  localparam int unsigned SigWidth  = 13;
  localparam int unsigned SigDepth  = 256;

  // Request kinds carried on the input side-band.
  typedef enum logic {
    OP_WRITE_WEIGHT = 1'b0,
    OP_FEED         = 1'b1
  } opcode_e;

  // Activation selected by the configuration register.
  typedef enum logic {
    ACT_IDENTITY = 1'b0,
    ACT_SIGMOID  = 1'b1
  } act_mode_e;

  typedef logic [SigDepth-1:0][SigWidth-1:0] sig_table_t;

  // Builds the logistic table at elaboration. Entry j covers 1/16 of [-8, 8);
  // the upper half is stepped through powers of e^-(1/16) in Q0.30 and each
  // lower-half entry is 4096 minus its mirrored upper-half entry.
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] r;
    step = (64'd1040706260 * 64'd1040706260 + (64'd1 << 29)) >> 30;
    e    = 64'd1040706260;
    for (int j = 0; j < 128; j++) begin
      d = (64'd1 << 30) + e;
      // Rounded quotient of 2^42 by d, by restoring long division.
      n = (64'd1 << 42) + (d >> 1);
      s = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[62:0], n[b]};
        if (r >= d) begin
          r    = r - d;
          s[b] = 1'b1;
        end
      end
      tbl[8'(128 + j)] = s[SigWidth-1:0];
      tbl[8'(127 - j)] = SigWidth'(64'd4096 - s);
      e = (e * step + (64'd1 << 29)) >> 30;
    end
    return tbl;
  endfunction

  localparam sig_table_t SigTable = build_sig_table();

endpackage

// ===== rtl/ndps_weight_mac.sv =====
// Weight store, input position counter, multiplier and 40-bit accumulator.
module ndps_weight_mac import ndps_pkg::*; #(
  parameter int unsigned MAX_INPUTS = 256,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  opcode_e                      opcode_i,
  input  logic [7:0]                   weight_index_i,
  input  logic signed [DATA_WIDTH-1:0] data_value_i,
  input  logic                         last_i,
  output logic                         sum_valid_o,
  input  logic                         sum_ready_i,
  output logic signed [AccWidth-1:0]   sum_o
);

  localparam int unsigned PosW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned IdxW  = (PosW > 8) ? PosW : 8;
  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam int unsigned ExtW  = (ProdW > AccWidth) ? ProdW : AccWidth;

  logic [DATA_WIDTH-1:0] weight_mem [MAX_INPUTS];

  logic [PosW-1:0] pos_q, pos_d;

  // Stage one: item plus the weight read from memory.
  logic                         v1_q;
  logic                         last1_q;
  logic signed [DATA_WIDTH-1:0] val1_q;
  logic signed [DATA_WIDTH-1:0] w1_q;

  // Stage two: registered product.
  logic                    v2_q;
  logic                    last2_q;
  logic signed [ProdW-1:0] prod2_q;

  // Stage three: running sum and the finished sum handed on.
  logic signed [AccWidth-1:0] acc_q;
  logic signed [AccWidth-1:0] sum_q;
  logic                       sum_valid_q;

  logic                       adv1, adv2, ready1, ready2;
  logic                       accept, feed_acc, write_acc, idx_ok;
  logic [IdxW-1:0]            widx;
  logic signed [ExtW-1:0]     prod_ext;
  logic signed [AccWidth-1:0] acc_sum;

  // Backpressure only reaches a stage when a finished sum is still held.
  always_comb begin
    adv2   = v2_q && (!last2_q || !sum_valid_q || sum_ready_i);
    ready2 = !v2_q || adv2;
    adv1   = v1_q && ready2;
    ready1 = !v1_q || ready2;
  end

  assign req_ready_o = ready1;
  assign accept      = req_valid_i && ready1;
  assign feed_acc    = accept && (opcode_i == OP_FEED);
  assign write_acc   = accept && (opcode_i == OP_WRITE_WEIGHT);
  assign widx        = IdxW'(weight_index_i);
  assign idx_ok      = 32'(weight_index_i) < 32'(MAX_INPUTS);

  // Position advances per feed item, wraps at the depth, clears on last.
  always_comb begin
    pos_d = pos_q;
    if (feed_acc) begin
      if (last_i || (pos_q == PosW'(MAX_INPUTS - 1))) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Weight store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (write_acc && idx_ok) begin
      weight_mem[widx[PosW-1:0]] <= data_value_i;
    end
    if (feed_acc) begin
      w1_q <= weight_mem[pos_q];
    end
  end

  // Payload registers of the first two stages.
  always_ff @(posedge clk_i) begin
    if (feed_acc) begin
      val1_q  <= data_value_i;
      last1_q <= last_i;
    end
    if (adv1) begin
      prod2_q <= val1_q * w1_q;
      last2_q <= last1_q;
    end
  end

  // Product widened or wrapped to the accumulator width.
  assign prod_ext = ExtW'(prod2_q);
  assign acc_sum  = acc_q + prod_ext[AccWidth-1:0];

  always_ff @(posedge clk_i) begin
    if (adv2 && last2_q) begin
      sum_q <= acc_sum;
    end
  end

  // Control state and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_q       <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      v1_q  <= feed_acc || (v1_q && !adv1);
      v2_q  <= adv1 || (v2_q && !adv2);
      if (adv2) begin
        acc_q <= last2_q ? '0 : acc_sum;
      end
      if (adv2 && last2_q) begin
        sum_valid_q <= 1'b1;
      end else if (sum_ready_i) begin
        sum_valid_q <= 1'b0;
      end
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

// ===== rtl/ndps_activation.sv =====
// Rounding and saturation of the sum, then identity or sigmoid table output.
module ndps_activation import ndps_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  act_mode_e                  mode_i,
  input  logic                       sum_valid_i,
  output logic                       sum_ready_o,
  input  logic signed [AccWidth-1:0] sum_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OutWidth-1:0]        activation_out_o,
  output logic                       saturated_o
);

  localparam int unsigned RndW = AccWidth + 1;
  localparam int unsigned QW   = RndW - FracBits;
  localparam int unsigned CmpW = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
  localparam int unsigned XW   = (DATA_WIDTH > OutWidth) ? DATA_WIDTH : OutWidth;
  localparam longint      HiL  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam logic signed [CmpW-1:0] SatHi = CmpW'(HiL);
  localparam logic signed [CmpW-1:0] SatLo = CmpW'(-HiL - 1);
  localparam logic signed [XW-1:0]   XMax  = XW'(32767);
  localparam logic signed [XW-1:0]   XMin  = XW'(-32768);

  logic                         v4_q;
  logic signed [DATA_WIDTH-1:0] qs_q;
  logic                         sat_q;
  logic                         ov_q;
  logic [OutWidth-1:0]          out_q;
  logic                         osat_q;

  logic                         ready4, ready5, adv4, load4;
  logic signed [RndW-1:0]       rnd;
  logic signed [CmpW-1:0]       q_ext;
  logic signed [DATA_WIDTH-1:0] qs_d;
  logic                         sat_d;
  logic signed [XW-1:0]         qw;
  logic signed [XW-1:0]         x16;
  logic [7:0]                   sig_idx;
  logic [OutWidth-1:0]          out_d;
  logic                         osat_d;

  assign ready5      = !ov_q || out_ready_i;
  assign adv4        = v4_q && ready5;
  assign ready4      = !v4_q || ready5;
  assign sum_ready_o = ready4;
  assign load4       = sum_valid_i && ready4;

  // Round half up to Q4.12, then clip to the data range.
  always_comb begin
    rnd   = RndW'(sum_i) + RndW'(2048);
    q_ext = CmpW'($signed(rnd[RndW-1:FracBits]));
    sat_d = 1'b0;
    if (q_ext > SatHi) begin
      qs_d  = SatHi[DATA_WIDTH-1:0];
      sat_d = 1'b1;
    end else if (q_ext < SatLo) begin
      qs_d  = SatLo[DATA_WIDTH-1:0];
      sat_d = 1'b1;
    end else begin
      qs_d = q_ext[DATA_WIDTH-1:0];
    end
  end

  // Identity passes the clipped value; sigmoid looks up one of 256 segments.
  always_comb begin
    qw = XW'(qs_q);
    if (qw > XMax) begin
      x16 = XMax;
    end else if (qw < XMin) begin
      x16 = XMin;
    end else begin
      x16 = qw;
    end
    sig_idx = {~x16[15], x16[14:8]};
    case (mode_i)
      ACT_IDENTITY: begin
        out_d  = qw[OutWidth-1:0];
        osat_d = sat_q;
      end
      default: begin
        out_d  = OutWidth'(SigTable[sig_idx]);
        osat_d = 1'b0;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load4) begin
      qs_q  <= qs_d;
      sat_q <= sat_d;
    end
    if (adv4) begin
      out_q  <= out_d;
      osat_q <= osat_d;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v4_q <= load4 || (v4_q && !adv4);
      ov_q <= adv4 || (ov_q && !out_ready_i);
    end
  end

  assign out_valid_o      = ov_q;
  assign activation_out_o = out_q;
  assign saturated_o      = osat_q;

endmodule

// ===== rtl/neuron_dot_product_sigmoid.sv =====
// Top level of the single neuron: weighted sum of a vector, then activation.
//
//   Channel   Direction  Request contents
//   s_axis    in         tdata {data_value, weight_index}, tuser opcode, tlast last_value
//   m_axis    out        tdata activation_out, tuser saturated
//   cfg       in         cfg_wdata_i activation_mode, written when cfg_we_i is high
//
// One request is taken per cycle while s_axis_tready is high; a feed request marked
// last shows its result on m_axis after passing five registers: weight memory read,
// multiplier register, accumulator, rounding stage and table stage.
// Reset clears the pipeline, accumulator and position and selects sigmoid mode;
// the weight store is not cleared and holds whatever was last written.
// s_axis_tready drops only while a result waits in the output register and every
// stage before it is full.
module neuron_dot_product_sigmoid import ndps_pkg::*; #(
  parameter int unsigned MAX_INPUTS = 256,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // weight_index [7:0], data_value [8 +: DATA_WIDTH], zero padding above
  input  logic [((8 + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // opcode [0]
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // activation_out [15:0]
  output logic [OutWidth-1:0]                   m_axis_tdata,
  // saturated [0]
  output logic                                  m_axis_tuser
);

  act_mode_e                    mode_q;
  logic                         sum_valid, sum_ready;
  logic signed [AccWidth-1:0]   sum;
  logic signed [DATA_WIDTH-1:0] data_value;

  // Activation mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ACT_SIGMOID;
    end else if (cfg_we_i) begin
      mode_q <= act_mode_e'(cfg_wdata_i);
    end
  end

  assign data_value = s_axis_tdata[8 +: DATA_WIDTH];

  ndps_weight_mac #(
    .MAX_INPUTS (MAX_INPUTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .opcode_i       (opcode_e'(s_axis_tuser)),
    .weight_index_i (s_axis_tdata[7:0]),
    .data_value_i   (data_value),
    .last_i         (s_axis_tlast),
    .sum_valid_o    (sum_valid),
    .sum_ready_i    (sum_ready),
    .sum_o          (sum)
  );

  ndps_activation #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_act (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .sum_valid_i      (sum_valid),
    .sum_ready_o      (sum_ready),
    .sum_i            (sum),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .activation_out_o (m_axis_tdata),
    .saturated_o      (m_axis_tuser)
  );

endmodule

// ===== rtl/ndps_checker.sv =====
// Port-level checks of the neuron block and their attachment to the top level.
module ndps_checker import ndps_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  localparam longint HiL = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam logic [OutWidth-1:0] ClipHi = OutWidth'(HiL);
  localparam logic [OutWidth-1:0] ClipLo = OutWidth'(-HiL - 1);

  // Reset empties the output register.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The input side stalls only behind an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // A clipped result sits at one end of the data range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == ClipHi || m_axis_tdata == ClipLo)
    else $error("saturated flag on an unclipped value");

endmodule

bind neuron_dot_product_sigmoid ndps_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ndps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
